/* rtl/core/mcbm_pkg.sv */
// Package for the minimum-count bin merger.
// Holds the beat types of both channels, the group record and the default sizes.
// Used by every module in rtl/core; depends on nothing.
package mcbm_pkg;

	localparam int unsigned CNT_W       = 32;
	localparam int unsigned BOUND_W     = 64;
	localparam int unsigned MIN_W       = 16;
	localparam logic [MIN_W-1:0] MIN_COUNT_RESET = 16'd5;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam int unsigned FIFO_DEPTH  = 4;

	typedef struct packed {
		logic [CNT_W-1:0]   bin_count;
		logic [BOUND_W-1:0] bin_low_bits;
		logic [BOUND_W-1:0] bin_up_bits;
		logic               last_bin;
	} bin_beat_t;

	typedef struct packed {
		logic [CNT_W-1:0]   merged_count;
		logic [BOUND_W-1:0] merged_low_bits;
		logic [BOUND_W-1:0] merged_up_bits;
		logic               final_bin;
	} merged_beat_t;

	typedef struct packed {
		logic [CNT_W-1:0]   count;
		logic [BOUND_W-1:0] low;
		logic [BOUND_W-1:0] up;
	} group_t;

	// Up to two results leave the merge logic per bin; they are packed so
	// that the first valid one always sits in slot 0.
	typedef struct packed {
		logic         v0;
		logic         v1;
		merged_beat_t r0;
		merged_beat_t r1;
	} push_t;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

endpackage

/* rtl/core/min_count_bin_merger.sv */
// Top level of the minimum-count bin merger: configuration register, merge
// logic and output queue. Depends on mcbm_pkg, mcbm_merge and mcbm_out_fifo.
//
// The block takes histogram bins in order, one beat per bin, and gathers
// adjacent bins until their saturating count sum reaches min_count. A merged
// bin keeps the lower bound of its first bin and the upper bound of its last.
// One finished bin is held back so that a short trailing group can be folded
// into it when the beat with last_bin arrives; that beat always produces the
// closing result, marked final_bin, and can produce two results when it also
// completes a group. A histogram that never reaches the minimum comes out as
// one bin. Bins are accepted one per cycle: each bin is resolved in a single
// pass of an add, a compare and a second add between the group registers and
// the output queue. The input stalls only when the output queue (DEPTH beats)
// holds more than DEPTH-2 beats, so with the output side draining every cycle
// the sustained rate is one bin per cycle, and results leave at one beat per
// cycle. min_count resets to 5 and must be written only while the block is
// idle; a write takes effect for the next bin.
module min_count_bin_merger #(
	parameter int unsigned DEPTH = mcbm_pkg::FIFO_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        bin_valid,
	output logic                        bin_stall,
	input  mcbm_pkg::bin_beat_t         bin_data,
	output logic                        merged_valid,
	input  logic                        merged_stall,
	output mcbm_pkg::merged_beat_t      merged_data,
	input  logic                        cfg_we,
	input  logic [mcbm_pkg::MIN_W-1:0]  cfg_wdata
);
	import mcbm_pkg::*;

	logic [MIN_W-1:0] min_count_q;
	logic             fire;
	logic             almost_full;
	push_t            push;

	// Stall is taken from the queue fill alone, never from the payload, so
	// the queue always has room for the two results a bin can cause.
	assign bin_stall = almost_full;
	assign fire      = bin_valid && !bin_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_count_q <= MIN_COUNT_RESET;
		end else if (cfg_we) begin
			min_count_q <= cfg_wdata;
		end
	end

	mcbm_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.beat      (bin_data),
		.min_count (min_count_q),
		.push      (push)
	);

	mcbm_out_fifo #(
		.DEPTH (DEPTH)
	) u_out_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.almost_full (almost_full),
		.out_valid   (merged_valid),
		.out_stall   (merged_stall),
		.out_beat    (merged_data)
	);

endmodule

/* rtl/core/mcbm_merge.sv */
// Merge logic of the minimum-count bin merger: the open group, the held group
// and the single-pass update that turns one bin into zero, one or two results.
// Depends on mcbm_pkg.
module mcbm_merge (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fire,
	input  mcbm_pkg::bin_beat_t       beat,
	input  logic [mcbm_pkg::MIN_W-1:0] min_count,
	output mcbm_pkg::push_t           push
);
	import mcbm_pkg::*;

	group_t acc_q;
	logic   acc_open_q;
	group_t held_q;
	logic   held_valid_q;

	group_t       grp;
	logic         complete;
	logic         emit_held;
	merged_beat_t held_res;
	merged_beat_t fin_res;

	always_comb begin
		// Extend the open group by this bin, or start a new one with it.
		if (acc_open_q) begin
			grp.count = sat_add(acc_q.count, beat.bin_count);
			grp.low   = acc_q.low;
		end else begin
			grp.count = beat.bin_count;
			grp.low   = beat.bin_low_bits;
		end
		grp.up = beat.bin_up_bits;

		complete  = grp.count >= {{(CNT_W-MIN_W){1'b0}}, min_count};
		emit_held = complete && held_valid_q;

		held_res = '{merged_count: held_q.count, merged_low_bits: held_q.low,
			merged_up_bits: held_q.up, final_bin: 1'b0};

		// Closing result of a histogram: a short trailing group folds into
		// the held one; otherwise the newest group stands alone.
		if (!complete && held_valid_q) begin
			fin_res = '{merged_count: sat_add(held_q.count, grp.count),
				merged_low_bits: held_q.low, merged_up_bits: grp.up, final_bin: 1'b1};
		end else begin
			fin_res = '{merged_count: grp.count, merged_low_bits: grp.low,
				merged_up_bits: grp.up, final_bin: 1'b1};
		end

		push.v0 = fire && (emit_held || beat.last_bin);
		push.v1 = fire && emit_held && beat.last_bin;
		push.r0 = emit_held ? held_res : fin_res;
		push.r1 = fin_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_open_q   <= 1'b0;
			held_valid_q <= 1'b0;
		end else if (fire) begin
			if (beat.last_bin) begin
				acc_open_q   <= 1'b0;
				held_valid_q <= 1'b0;
			end else if (complete) begin
				acc_open_q   <= 1'b0;
				held_valid_q <= 1'b1;
			end else begin
				acc_open_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && !beat.last_bin) begin
			if (complete) begin
				held_q <= grp;
			end else begin
				acc_q <= grp;
			end
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && beat.last_bin |=> !acc_open_q && !held_valid_q)
		else $error("group state not cleared after the last bin");

	a_pair_packed: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> push.v0)
		else $error("second result pushed without the first");

	a_pair_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> held_valid_q && beat.last_bin && push.r1.final_bin)
		else $error("two results from a bin that does not end the histogram");

endmodule

/* rtl/core/mcbm_out_fifo.sv */
// Output queue of the minimum-count bin merger: takes up to two result beats
// per cycle, hands out one, and flags when room for two more is not assured.
// Depends on mcbm_pkg.
module mcbm_out_fifo #(
	parameter int unsigned DEPTH = mcbm_pkg::FIFO_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mcbm_pkg::push_t        push,
	output logic                   almost_full,
	output logic                   out_valid,
	input  logic                   out_stall,
	output mcbm_pkg::merged_beat_t out_beat
);
	import mcbm_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	merged_beat_t    mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            pop;
	logic [PW-1:0]   wr_ptr_p1;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign out_valid   = count_q != '0;
	assign out_beat    = mem_q[rd_ptr_q];
	assign pop         = out_valid && !out_stall;
	assign almost_full = count_q > CW'(DEPTH - 2);
	assign wr_ptr_p1   = ptr_inc(wr_ptr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.v1) begin
				wr_ptr_q <= ptr_inc(wr_ptr_p1);
			end else if (push.v0) begin
				wr_ptr_q <= wr_ptr_p1;
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + CW'(push.v0) + CW'(push.v1) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[wr_ptr_p1] <= push.r1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.v0 |-> count_q <= CW'(DEPTH - 1) && (!push.v1 || count_q <= CW'(DEPTH - 2)))
		else $error("result queue overflow");

endmodule
